// ----- sv/wsp_pkg.sv -----
// wsp_pkg: shared widths, register indexes, result types and helpers
// for the world-to-screen projection pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

  localparam int COORD_W = 24;
  localparam int ENT_W   = 16;
  localparam int PROD_W  = ENT_W + COORD_W;
  localparam int CLIP_W  = 42;
  localparam int MAG_W   = CLIP_W + 1;
  localparam int SCALE_W = 23;
  localparam int QB      = 27;
  localparam int RES_W   = QB + 2;
  localparam int SUM_W   = RES_W + 1;
  localparam int N2_W    = MAG_W + SCALE_W + 1;
  localparam int QUOT_LAT = QB + 4;
  localparam int ROW_W   = 4 * ENT_W;
  localparam int VP_W    = 32;
  localparam int HALF_W  = 16;
  localparam int FRAC_W  = 8;

  localparam logic signed [CLIP_W-1:0] W_EPS = CLIP_W'(7);
  localparam logic [SCALE_W-1:0] DEPTH_SCALE = SCALE_W'(65536);

  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_ROW_W  = 3'd3,
    REG_ORIGIN = 3'd4,
    REG_SIZE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic              behind;
    logic              outside;
    logic [MAG_W-1:0]  mag_x;
    logic              neg_x;
    logic [MAG_W-1:0]  mag_y;
    logic              neg_y;
    logic [MAG_W-1:0]  mag_z;
    logic              neg_z;
    logic [CLIP_W-1:0] w;
  } clip_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(8388607);
    lo = -SUM_W'(8388608);
    if (v > hi) return hi[COORD_W-1:0];
    else if (v < lo) return lo[COORD_W-1:0];
    else return v[COORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/world_to_screen_projection_top.sv -----
// world_to_screen_projection_top: config registers, transform stage, three
// divide lanes and output stage; depends on wsp_pkg, wsp_xform, wsp_quot
//
// usage: world points (Q16.8) enter on the in_ channel, one transaction per
// cycle; each yields one result transaction on the out_ channel carrying
// screen x/y (Q16.8 pixels), depth (Q8.16) and the behind/outside flags.
// from input to output register the stages are the matrix multiply, clamp
// and numerator setup, then in each divide lane a split multiply, range check,
// one quotient bit per stage and rounding, and last offset and saturation.
// throughput is one point per cycle while the output is not stalled.
// the whole pipeline advances together; when the output register is full
// and out_ready is low, every stage holds and in_ready drops, so nothing
// is lost or repeated.
// the cfg_ channel writes the four matrix rows, viewport origin and size;
// it is always ready and should be written only with the pipeline empty.
// reset (synchronous, active low) clears all valid bits and loads the
// identity matrix, origin 0,0 and a 640x480 viewport.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_top import wsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_world_x,
  input  logic signed [COORD_W-1:0] in_world_y,
  input  logic signed [COORD_W-1:0] in_world_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y,
  output logic signed [COORD_W-1:0] out_depth,
  output logic                      out_behind_camera,
  output logic                      out_outside_viewport,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [ROW_W-1:0]          cfg_data
);

  logic [3:0][ROW_W-1:0] mrow_r;
  logic [VP_W-1:0]       origin_r, size_r;
  logic                  adv;
  clip_t                 xf;

  logic [HALF_W-1:0]         vw, vh;
  logic [SCALE_W-1:0]        scale_x, scale_y;
  logic signed [RES_W-1:0]   res_x, res_y, res_z;
  logic signed [COORD_W-1:0] off_x, off_y;

  logic sv_r [QUOT_LAT];
  logic sb_r [QUOT_LAT];
  logic so_r [QUOT_LAT];

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] sx_r, sy_r, dz_r;
  logic                      behind_r, outside_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrow_r[0] <= ROW_W'(256);
      mrow_r[1] <= ROW_W'(256) << ENT_W;
      mrow_r[2] <= ROW_W'(256) << (2 * ENT_W);
      mrow_r[3] <= ROW_W'(256) << (3 * ENT_W);
      origin_r  <= '0;
      size_r    <= {HALF_W'(480), HALF_W'(640)};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_X:  mrow_r[0] <= cfg_data;
        REG_ROW_Y:  mrow_r[1] <= cfg_data;
        REG_ROW_Z:  mrow_r[2] <= cfg_data;
        REG_ROW_W:  mrow_r[3] <= cfg_data;
        REG_ORIGIN: origin_r  <= cfg_data[VP_W-1:0];
        REG_SIZE:   size_r    <= cfg_data[VP_W-1:0];
        default: ;
      endcase
    end
  end

  wsp_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .world_x  (in_world_x),
    .world_y  (in_world_y),
    .world_z  (in_world_z),
    .mrow     (mrow_r),
    .res_o    (xf)
  );

  always_comb begin
    vw = (size_r[HALF_W-1:0] == '0) ? HALF_W'(1) : size_r[HALF_W-1:0];
    vh = (size_r[VP_W-1:HALF_W] == '0) ? HALF_W'(1) : size_r[VP_W-1:HALF_W];
    scale_x = {vw, 7'b0};
    scale_y = {vh, 7'b0};
    off_x = {origin_r[HALF_W-1:0], {FRAC_W{1'b0}}};
    off_y = {origin_r[VP_W-1:HALF_W], {FRAC_W{1'b0}}};
  end

  wsp_quot u_quot_x (
    .clk (clk), .adv (adv), .mag (xf.mag_x), .neg (xf.neg_x), .w (xf.w),
    .scale (scale_x), .res (res_x)
  );

  wsp_quot u_quot_y (
    .clk (clk), .adv (adv), .mag (xf.mag_y), .neg (xf.neg_y), .w (xf.w),
    .scale (scale_y), .res (res_y)
  );

  wsp_quot u_quot_z (
    .clk (clk), .adv (adv), .mag (xf.mag_z), .neg (xf.neg_z), .w (xf.w),
    .scale (DEPTH_SCALE), .res (res_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUOT_LAT; i++) sv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= xf.valid;
      for (int i = 1; i < QUOT_LAT; i++) sv_r[i] <= sv_r[i-1];
      out_valid_r <= sv_r[QUOT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= xf.behind;
      so_r[0] <= xf.outside;
      for (int i = 1; i < QUOT_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
        so_r[i] <= so_r[i-1];
      end
      sx_r      <= sat24(SUM_W'(res_x) + SUM_W'(off_x));
      sy_r      <= sat24(SUM_W'(res_y) + SUM_W'(off_y));
      dz_r      <= sat24(SUM_W'(res_z));
      behind_r  <= sb_r[QUOT_LAT-1];
      outside_r <= so_r[QUOT_LAT-1];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_screen_x         = sx_r;
  assign out_screen_y         = sy_r;
  assign out_depth            = dz_r;
  assign out_behind_camera    = behind_r;
  assign out_outside_viewport = outside_r;

endmodule
`default_nettype wire

// ----- sv/wsp_xform.sv -----
// wsp_xform: three stages for matrix times point, w clamp, outside test
// and numerator magnitudes; depends on wsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module wsp_xform import wsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] world_x,
  input  logic signed [COORD_W-1:0] world_y,
  input  logic signed [COORD_W-1:0] world_z,
  input  logic [3:0][ROW_W-1:0]     mrow,
  output clip_t                     res_o
);

  logic signed [COORD_W-1:0] pt [3];
  logic signed [PROD_W-1:0]  prod_r [4][3];
  logic signed [ENT_W-1:0]   wt_r [4];
  logic signed [CLIP_W-1:0]  clip_r [4];
  logic                      v1_r, v2_r;
  clip_t                     res_r, res_nxt;

  logic signed [CLIP_W-1:0]  wc;
  logic signed [MAG_W-1:0]   nx, ny, nz, wc_e, wn_e;
  logic signed [MAG_W-1:0]   c0, c1, c2;

  assign pt[0] = world_x;
  assign pt[1] = world_y;
  assign pt[2] = world_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(mrow[r][ENT_W*c +: ENT_W]) * pt[c];
        end
        wt_r[r] <= $signed(mrow[r][ENT_W*3 +: ENT_W]);
        clip_r[r] <= CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1]) + CLIP_W'(prod_r[r][2])
                   + (CLIP_W'(wt_r[r]) <<< FRAC_W);
      end
      res_r <= res_nxt;
    end
  end

  always_comb begin
    res_nxt.valid = v2_r;
    res_nxt.behind = (clip_r[3] <= W_EPS);
    wc = res_nxt.behind ? W_EPS : clip_r[3];
    wc_e = MAG_W'(wc);
    wn_e = -wc_e;
    c0 = MAG_W'(clip_r[0]);
    c1 = MAG_W'(clip_r[1]);
    c2 = MAG_W'(clip_r[2]);
    nx = c0 + wc_e;
    ny = wc_e - c1;
    nz = c2;
    res_nxt.outside = (c0 < wn_e) || (c0 > wc_e) || (c1 < wn_e) || (c1 > wc_e)
                   || (c2 < 0) || (c2 > wc_e);
    res_nxt.neg_x = nx[MAG_W-1];
    res_nxt.neg_y = ny[MAG_W-1];
    res_nxt.neg_z = nz[MAG_W-1];
    res_nxt.mag_x = nx[MAG_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
    res_nxt.mag_y = ny[MAG_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
    res_nxt.mag_z = nz[MAG_W-1] ? MAG_W'(-nz) : MAG_W'(nz);
    res_nxt.w = wc;
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

// ----- sv/wsp_quot.sv -----
// wsp_quot: pipelined round(mag * scale / w) with overflow cap,
// split multiply then one restoring divide step per stage; depends on wsp_pkg
`timescale 1ns / 1ps
`default_nettype none
module wsp_quot import wsp_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [MAG_W-1:0]        mag,
  input  logic                    neg,
  input  logic [CLIP_W-1:0]       w,
  input  logic [SCALE_W-1:0]      scale,
  output logic signed [RES_W-1:0] res
);

  localparam int LO_W = 22;
  localparam int HI_W = MAG_W - LO_W;

  logic [LO_W+SCALE_W-1:0] pplo_r;
  logic [HI_W+SCALE_W-1:0] pphi_r;
  logic [CLIP_W-1:0]       wa_r, wb_r;
  logic                    nega_r, negb_r;
  logic [N2_W-1:0]         n2_r;

  logic [CLIP_W-1:0] rem_r [QB+1];
  logic [QB-1:0]     low_r [QB+1];
  logic [QB-1:0]     q_r   [QB+1];
  logic [CLIP_W-1:0] w_r   [QB+1];
  logic              neg_r [QB+1];
  logic              ovf_r [QB+1];

  logic [QB:0]             t_inc;
  logic signed [RES_W-1:0] mag_f;
  logic signed [RES_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pplo_r <= mag[LO_W-1:0] * scale;
      pphi_r <= mag[MAG_W-1:LO_W] * scale;
      wa_r   <= w;
      nega_r <= neg;
      n2_r   <= (N2_W'(pphi_r) << (LO_W + 1)) + (N2_W'(pplo_r) << 1);
      wb_r   <= wa_r;
      negb_r <= nega_r;
      rem_r[0] <= CLIP_W'(n2_r[N2_W-1:QB]);
      low_r[0] <= n2_r[QB-1:0];
      q_r[0]   <= '0;
      w_r[0]   <= wb_r;
      neg_r[0] <= negb_r;
      ovf_r[0] <= (CLIP_W'(n2_r[N2_W-1:QB]) >= wb_r);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CLIP_W:0] trial, diff;
    logic            ge;
    assign trial = {rem_r[k], low_r[k][QB-1]};
    assign diff  = trial - {1'b0, w_r[k]};
    assign ge    = (trial >= {1'b0, w_r[k]});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= ge ? diff[CLIP_W-1:0] : trial[CLIP_W-1:0];
        low_r[k+1] <= {low_r[k][QB-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        w_r[k+1]   <= w_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_comb begin
    t_inc = (QB+1)'(q_r[QB]) + (QB+1)'(1);
    mag_f = ovf_r[QB] ? (RES_W'(1) <<< QB) : RES_W'(t_inc[QB:1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= neg_r[QB] ? -mag_f : mag_f;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ----- tb/wsp_projection_checker.sv -----
// wsp_projection_checker: watches the cfg_, in_ and out_ channels of the
// projection block, predicts each result and compares it; depends on wsp_pkg
`timescale 1ns / 1ps
module wsp_projection_checker import wsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_world_x,
  input  logic signed [COORD_W-1:0] in_world_y,
  input  logic signed [COORD_W-1:0] in_world_z,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] out_screen_x,
  input  logic signed [COORD_W-1:0] out_screen_y,
  input  logic signed [COORD_W-1:0] out_depth,
  input  logic                      out_behind_camera,
  input  logic                      out_outside_viewport,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [ROW_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        points_checked
);

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] dz;
    logic               behind;
    logic               outside;
  } screen_pt_t;

  logic [ROW_W-1:0] mat_row [4];
  logic [VP_W-1:0]  vp_org;
  logic [VP_W-1:0]  vp_sz;
  screen_pt_t       pending_pts [$];

  function automatic longint entry(input logic [ROW_W-1:0] row, input int col);
    logic signed [ENT_W-1:0] e;
    e = row[16*col +: 16];
    return longint'(e);
  endfunction

  // round(n * s / d), ties away from zero, capped when the quotient is huge
  function automatic longint div_round(input longint n, input longint unsigned s,
                                       input longint d);
    logic neg;
    longint unsigned mag, ud, q, r, t, f, total;
    neg = n < 0;
    mag = neg ? longint'(0) - n : n;
    ud = d;
    q = mag / ud;
    r = mag % ud;
    if (q > (64'd1 << 18)) return neg ? -(longint'(1) <<< 40) : (longint'(1) <<< 40);
    t = r * s;
    f = t / ud;
    if (2 * (t % ud) >= ud) f = f + 1;
    total = q * s + f;
    return neg ? -longint'(total) : longint'(total);
  endfunction

  function automatic logic [COORD_W-1:0] clamp24(input longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[COORD_W-1:0];
  endfunction

  function automatic screen_pt_t project(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic signed [COORD_W-1:0] z);
    longint p [4];
    longint clip [4];
    longint w, vx, vy;
    longint unsigned vw, vh;
    logic signed [HALF_W-1:0] ox, oy;
    screen_pt_t res;
    p[0] = longint'(x);
    p[1] = longint'(y);
    p[2] = longint'(z);
    p[3] = 256;
    for (int r = 0; r < 4; r++) begin
      clip[r] = 0;
      for (int c = 0; c < 4; c++) clip[r] += entry(mat_row[r], c) * p[c];
    end
    w = clip[3];
    res.behind = w <= 7;
    if (res.behind) w = 7;
    ox = vp_org[15:0];
    oy = vp_org[31:16];
    vx = longint'(ox);
    vy = longint'(oy);
    vw = vp_sz[15:0];
    vh = vp_sz[31:16];
    if (vw == 0) vw = 1;
    if (vh == 0) vh = 1;
    res.sx = clamp24(vx * 256 + div_round(clip[0] + w, vw * 128, w));
    res.sy = clamp24(vy * 256 + div_round(w - clip[1], vh * 128, w));
    res.dz = clamp24(div_round(clip[2], 65536, w));
    res.outside = clip[0] < -w || clip[0] > w || clip[1] < -w || clip[1] > w ||
                  clip[2] < 0 || clip[2] > w;
    return res;
  endfunction

  always @(posedge clk) begin
    screen_pt_t want, got;
    if (!rst_n) begin
      mat_row[0] <= 64'd256;
      mat_row[1] <= 64'd256 << 16;
      mat_row[2] <= 64'd256 << 32;
      mat_row[3] <= 64'd256 << 48;
      vp_org <= '0;
      vp_sz <= {16'd480, 16'd640};
      pending_pts.delete();
      fail_count <= 0;
      pending <= 0;
      points_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_X:  mat_row[0] <= cfg_data;
          REG_ROW_Y:  mat_row[1] <= cfg_data;
          REG_ROW_Z:  mat_row[2] <= cfg_data;
          REG_ROW_W:  mat_row[3] <= cfg_data;
          REG_ORIGIN: vp_org <= cfg_data[VP_W-1:0];
          REG_SIZE:   vp_sz <= cfg_data[VP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_pts.push_back(project(in_world_x, in_world_y, in_world_z));
      if (out_valid && out_ready) begin
        got = '{out_screen_x, out_screen_y, out_depth, out_behind_camera, out_outside_viewport};
        if (pending_pts.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          want = pending_pts.pop_front();
          points_checked <= points_checked + 1;
          if (got.sx !== want.sx || got.sy !== want.sy || got.dz !== want.dz ||
              got.behind !== want.behind || got.outside !== want.outside) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch at %0t: exp sx=%h sy=%h dz=%h b=%b o=%b got sx=%h sy=%h dz=%h b=%b o=%b",
                       $realtime, want.sx, want.sy, want.dz, want.behind, want.outside,
                       got.sx, got.sy, got.dz, got.behind, got.outside);
          end
        end
      end
      pending <= pending_pts.size();
    end
  end

endmodule

// ----- tb/tb_world_to_screen_projection_top.sv -----
// tb_world_to_screen_projection_top: stimulus, idling and verdict for the
// projection block; depends on wsp_pkg, the block and wsp_projection_checker
`timescale 1ns / 1ps
module tb_world_to_screen_projection_top;
  import wsp_pkg::*;

  localparam logic [2:0] REG_UNUSED_A = 3'd6;
  localparam logic [2:0] REG_UNUSED_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_world_x = '0, in_world_y = '0, in_world_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_screen_x, out_screen_y, out_depth;
  logic out_behind_camera, out_outside_viewport;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;
  int fail_count, pending, points_checked;
  int points_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  world_to_screen_projection_top uut (.*);
  wsp_projection_checker chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ready = quiet || ($urandom_range(99) >= 23);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [ROW_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_world_x = x;
    in_world_y = y;
    in_world_z = z;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return COORD_W'($urandom);
    if (sel == 1) return COORD_W'($signed($urandom_range(65535)) - 32768);
    return COORD_W'($signed($urandom_range(2047)) - 1024);
  endfunction

  function automatic logic [ENT_W-1:0] rand_entry(input int span);
    return ENT_W'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic load_sane();
    write_reg(REG_ROW_X, {rand_entry(64), rand_entry(8), rand_entry(64), rand_entry(384)});
    write_reg(REG_ROW_Y, {rand_entry(64), rand_entry(64), rand_entry(384), rand_entry(8)});
    write_reg(REG_ROW_Z, {rand_entry(128), rand_entry(256), rand_entry(8), rand_entry(8)});
    write_reg(REG_ROW_W, {16'($urandom_range(1024)), rand_entry(256),
                          rand_entry(16), rand_entry(16)});
    write_reg(REG_ORIGIN, {32'd0, 16'($urandom_range(200)), 16'($urandom_range(200))});
    write_reg(REG_SIZE, {32'd0, 16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))});
  endtask

  initial begin
    logic [COORD_W-1:0] one, top, bot;
    one = 24'd256;
    top = 24'h7fffff;
    bot = 24'h800000;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // identity, default viewport: center, borders, extremes, negative depth
    send_point('0, '0, '0);
    send_point(one, one, one);
    send_point(-one, -one, '0);
    send_point(one + 1, '0, one);
    send_point('0, '0, -24'sd1);
    send_point(top, top, top);
    send_point(bot, bot, bot);
    send_point(top, bot, '0);
    drain();
    // clip w zero: behind the camera, w clamped
    write_reg(REG_ROW_W, '0);
    send_point(one, -one, one);
    send_point(top, bot, top);
    drain();
    // negative w, zero-sized viewport, extreme origin
    write_reg(REG_ROW_W, {16'h8000, 48'd0});
    write_reg(REG_SIZE, '0);
    write_reg(REG_ORIGIN, {32'd0, 32'h8000_7fff});
    send_point('0, '0, '0);
    send_point(one, one, one);
    drain();
    write_reg(REG_ROW_W, {16'd256, 48'd0});
    send_point(one, one, '0);
    send_point(-one, -one, one);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_ROW_X, 64'd256);
          write_reg(REG_ROW_Y, 64'd256 << 16);
          write_reg(REG_ROW_Z, 64'd256 << 32);
          write_reg(REG_ROW_W, 64'd256 << 48);
          write_reg(REG_ORIGIN, '0);
          write_reg(REG_SIZE, {32'd0, 16'd480, 16'd640});
          write_reg(REG_UNUSED_A, {$urandom, $urandom});
        end
        2: begin
          write_reg(REG_ROW_X, {$urandom, $urandom});
          write_reg(REG_ROW_Y, {$urandom, $urandom});
          write_reg(REG_ROW_Z, {$urandom, $urandom});
          write_reg(REG_ROW_W, {$urandom, $urandom});
          write_reg(REG_ORIGIN, {$urandom, $urandom});
          write_reg(REG_SIZE, {$urandom, $urandom});
        end
        3: begin
          write_reg(REG_ROW_X, {4{16'h7fff}});
          write_reg(REG_ROW_Y, {4{16'h7fff}});
          write_reg(REG_ROW_Z, {4{16'h7fff}});
          write_reg(REG_ROW_W, {4{16'h7fff}});
          write_reg(REG_ORIGIN, {32'd0, 32'h8000_8000});
          write_reg(REG_SIZE, {32'd0, 32'hffff_ffff});
        end
        4: begin
          write_reg(REG_ROW_X, {4{16'h8000}});
          write_reg(REG_ROW_Y, {4{16'h8000}});
          write_reg(REG_ROW_Z, {4{16'h8000}});
          write_reg(REG_ROW_W, {4{16'h8000}});
          write_reg(REG_ORIGIN, {32'd0, 32'h7fff_7fff});
          write_reg(REG_SIZE, '0);
          write_reg(REG_UNUSED_B, {$urandom, $urandom});
        end
        default: load_sane();
      endcase
      quiet = (ph == 5);
      for (int i = 0; i < 142; i++) begin
        if (ph == 1 && i == 20) hold_req = 1'b1;
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
      quiet = 1'b0;
      drain();
    end

    $display("sent %0d points over 8 register settings plus directed cases; %0d results checked",
             points_sent, points_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
